### rtl/brs_pkg.sv
// brs_pkg: shared types, register codes and widths for the boxcar-rise / exp-decay shaper
// used by brs_cell, brs_window, brs_iir and boxcar_rise_exp_decay_shaper_core
`timescale 1ns / 1ps

package brs_pkg;

	// default structure sizes
	localparam int RISE_MAX_DEF    = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	// fixed field widths
	localparam int CHARGE_W  = 16;
	localparam int DECAY_W   = 16;
	localparam int WLEN_W    = 7;
	localparam int RECIP_W   = 17;
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 2;
	localparam int SHAPED_W  = 48;
	localparam int FRAC_W    = 16;
	localparam int OUT_W     = 32;

	// register reset values
	localparam logic [DECAY_W-1:0] DECAY_RST = 16'd63488;
	localparam logic [WLEN_W-1:0]  WLEN_RST  = 7'd1;
	localparam logic [RECIP_W-1:0] RECIP_RST = 17'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DECAY  = 2'd0,
		REG_WINDOW = 2'd1,
		REG_RECIP  = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [CHARGE_W-1:0] charge;
		logic                start_of_record;
	} in_item_t;

	typedef struct packed {
		logic [OUT_W-1:0] shaped;
		logic             saturated;
	} out_item_t;

	// per-cell control from the window logic
	typedef struct packed {
		logic write;
		logic clear;
		logic active;
	} cell_ctl_t;

	// first pipeline stage as seen by the filter stages
	typedef struct packed {
		logic valid;
		logic clear;
	} stage_t;

endpackage

### rtl/brs_cell.sv
// brs_cell: one slot of the rise window ring plus one stage of the partial-sum chain
// depends on brs_pkg
`timescale 1ns / 1ps

module brs_cell #(
	parameter int SAMPLE_BITS = brs_pkg::SAMPLE_BITS_DEF,
	parameter int TOT_W       = brs_pkg::SAMPLE_BITS_DEF + 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  brs_pkg::cell_ctl_t     ctl,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [TOT_W-1:0]       psum_in,
	output logic [TOT_W-1:0]       psum_out,
	output logic [SAMPLE_BITS-1:0] hit_value
);

	logic [SAMPLE_BITS-1:0] value_q;
	logic [TOT_W-1:0]       psum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (ctl.write) begin
			value_q <= sample;
		end else if (ctl.clear) begin
			value_q <= '0;
		end
	end

	// running partial sum handed to the next cell
	always_ff @(posedge clk) begin
		psum_q <= psum_in + (ctl.active ? TOT_W'(value_q) : '0);
	end

	assign psum_out  = psum_q;
	assign hit_value = ctl.write ? value_q : '0;

endmodule

### rtl/brs_window.sv
// brs_window: ring of brs_cell slots, write pointer and running window total
// depends on brs_pkg and brs_cell
`timescale 1ns / 1ps

module brs_window #(
	parameter int RISE_MAX    = brs_pkg::RISE_MAX_DEF,
	parameter int SAMPLE_BITS = brs_pkg::SAMPLE_BITS_DEF,
	parameter int TOT_W       = brs_pkg::SAMPLE_BITS_DEF + 6,
	parameter int LEN_W       = 7
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic                   start,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [LEN_W-1:0]       len,
	input  logic                   reload,
	output logic                   busy,
	output logic [TOT_W-1:0]       total
);

	localparam int SLOT_W = $clog2(RISE_MAX);
	localparam int CNT_W  = $clog2(RISE_MAX + 2);

	logic [SLOT_W-1:0]      wslot_q;
	logic [SLOT_W-1:0]      cur_slot;
	logic [SLOT_W-1:0]      next_slot;
	logic [LEN_W-1:0]       next_len;
	logic [CNT_W-1:0]       cnt_q;
	logic [TOT_W-1:0]       total_q;
	logic [SAMPLE_BITS-1:0] old_value;
	logic [SAMPLE_BITS-1:0] hit [RISE_MAX];
	logic [TOT_W-1:0]       psum [RISE_MAX+1];

	// a slot left outside a shrunk window falls back to slot zero
	always_comb begin
		if (start) begin
			cur_slot = '0;
		end else if (LEN_W'(wslot_q) < len) begin
			cur_slot = wslot_q;
		end else begin
			cur_slot = '0;
		end
		next_len  = LEN_W'(cur_slot) + LEN_W'(1);
		next_slot = (next_len >= len) ? '0 : SLOT_W'(next_len);
	end

	assign psum[0] = '0;

	for (genvar i = 0; i < RISE_MAX; i++) begin : g_cell
		brs_pkg::cell_ctl_t ctl;

		assign ctl.write  = accept && (cur_slot == SLOT_W'(i));
		assign ctl.clear  = accept && start;
		assign ctl.active = (LEN_W'(i) < len);

		brs_cell #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.TOT_W      (TOT_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.sample   (sample),
			.psum_in  (psum[i]),
			.psum_out (psum[i+1]),
			.hit_value(hit[i])
		);
	end

	always_comb begin
		old_value = '0;
		for (int i = 0; i < RISE_MAX; i++) begin
			old_value = old_value | hit[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wslot_q <= '0;
			cnt_q   <= '0;
			total_q <= '0;
		end else begin
			if (reload) begin
				cnt_q <= CNT_W'(RISE_MAX + 1);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (accept) begin
				wslot_q <= next_slot;
				if (start) begin
					total_q <= TOT_W'(sample);
				end else begin
					total_q <= total_q - TOT_W'(old_value) + TOT_W'(sample);
				end
			end else if (cnt_q == CNT_W'(1)) begin
				// chain has settled on the new window, take its sum
				total_q <= psum[RISE_MAX];
			end
		end
	end

	assign busy  = (cnt_q != '0);
	assign total = total_q;

endmodule

### rtl/brs_iir.sv
// brs_iir: boxcar average multiply, single-pole decay update and output register
// depends on brs_pkg
`timescale 1ns / 1ps

module brs_iir #(
	parameter int TOT_W = brs_pkg::SAMPLE_BITS_DEF + 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  brs_pkg::stage_t                s1,
	input  logic [TOT_W-1:0]               total,
	input  logic [brs_pkg::RECIP_W-1:0]    recip,
	input  logic [brs_pkg::DECAY_W-1:0]    decay,
	input  logic                           result_stall,
	output logic                           take,
	output logic                           result_valid,
	output brs_pkg::out_item_t             result
);

	localparam int AVG_W = TOT_W + brs_pkg::RECIP_W;
	localparam int DEC_W = brs_pkg::SHAPED_W + brs_pkg::DECAY_W;
	localparam int SUM_W = ((AVG_W > brs_pkg::SHAPED_W) ? AVG_W : brs_pkg::SHAPED_W) + 1;

	logic                         v_s2;
	logic                         clear_s2;
	logic [AVG_W-1:0]             avg_s2;
	logic                         v_q;
	logic [brs_pkg::SHAPED_W-1:0] shaped_q;
	logic                         sat_q;
	logic                         en2;
	logic                         en3;
	logic [brs_pkg::SHAPED_W-1:0] base;
	logic [DEC_W-1:0]             prod;
	logic [SUM_W-1:0]             sum;
	logic                         sat;

	assign en3  = !v_q || !result_stall;
	assign en2  = !v_s2 || en3;
	assign take = en2;

	always_comb begin
		base = clear_s2 ? '0 : shaped_q;
		prod = DEC_W'(base) * DEC_W'(decay);
		sum  = SUM_W'(prod[DEC_W-1:brs_pkg::FRAC_W]) + SUM_W'(avg_s2);
		sat  = |sum[SUM_W-1:brs_pkg::SHAPED_W];
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			avg_s2   <= AVG_W'(total) * AVG_W'(recip);
			clear_s2 <= s1.clear;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2     <= 1'b0;
			v_q      <= 1'b0;
			shaped_q <= '0;
			sat_q    <= 1'b0;
		end else begin
			if (en2) begin
				v_s2 <= s1.valid;
			end
			if (en3) begin
				v_q <= v_s2;
				if (v_s2) begin
					shaped_q <= sat ? '1 : sum[brs_pkg::SHAPED_W-1:0];
					sat_q    <= sat;
				end
			end
		end
	end

	assign result_valid     = v_q;
	assign result.shaped    = shaped_q[brs_pkg::SHAPED_W-1:brs_pkg::FRAC_W];
	assign result.saturated = sat_q;

endmodule

### rtl/boxcar_rise_exp_decay_shaper_core.sv
// Boxcar-rise, exponential-decay pulse shaper. Takes one charge sample per clock while the
// input is not stalled and gives one shaped value per sample, passed through the s1, s2
// and output registers. The rise window is a row of RISE_MAX cells holding the samples;
// the window total is kept by adding the new sample and dropping the one it overwrites,
// and the decay loop is one multiply-add per cycle while the output is not stalled.
// After a write of window_length the input is stalled while the cell chain rebuilds the
// window total. Reset clears the whole ring at once.
// depends on brs_pkg, brs_window, brs_iir
`timescale 1ns / 1ps

module boxcar_rise_exp_decay_shaper_core #(
	parameter int RISE_MAX    = brs_pkg::RISE_MAX_DEF,
	parameter int SAMPLE_BITS = brs_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  brs_pkg::in_item_t               item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output brs_pkg::out_item_t              result,
	input  logic                            cfg_wen,
	input  logic [brs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [brs_pkg::CFG_W-1:0]       cfg_data
);

	localparam int TOT_W = SAMPLE_BITS + $clog2(RISE_MAX);
	localparam int LEN_W = $clog2(RISE_MAX + 1);
	localparam int CMP_W = (LEN_W > brs_pkg::WLEN_W) ? LEN_W : brs_pkg::WLEN_W;

	logic [brs_pkg::DECAY_W-1:0] decay_q;
	logic [brs_pkg::WLEN_W-1:0]  wlen_q;
	logic [brs_pkg::RECIP_W-1:0] recip_q;
	logic [LEN_W-1:0]            len_eff;
	logic [CMP_W-1:0]            wlen_ext;
	logic                        reload;
	logic                        busy;
	logic                        take;
	logic                        en1;
	logic                        accept;
	logic [SAMPLE_BITS-1:0]      sample;
	logic [TOT_W-1:0]            total;
	logic                        v_s1;
	logic                        clear_s1;
	brs_pkg::stage_t             s1;

	// window length clamped to 1..RISE_MAX
	always_comb begin
		wlen_ext = CMP_W'(wlen_q);
		if (wlen_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (wlen_ext > CMP_W'(RISE_MAX)) begin
			len_eff = LEN_W'(RISE_MAX);
		end else begin
			len_eff = LEN_W'(wlen_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= brs_pkg::DECAY_RST;
			wlen_q  <= brs_pkg::WLEN_RST;
			recip_q <= brs_pkg::RECIP_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				brs_pkg::REG_DECAY: begin
					decay_q <= cfg_data[brs_pkg::DECAY_W-1:0];
				end
				brs_pkg::REG_WINDOW: begin
					wlen_q <= cfg_data[brs_pkg::WLEN_W-1:0];
				end
				brs_pkg::REG_RECIP: begin
					recip_q <= cfg_data[brs_pkg::RECIP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign reload     = cfg_wen && (cfg_index == brs_pkg::REG_WINDOW);
	assign en1        = !v_s1 || take;
	assign item_stall = !en1 || busy;
	assign accept     = item_valid && !item_stall;
	assign sample     = SAMPLE_BITS'(item.charge);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			clear_s1 <= item.start_of_record;
		end
	end

	assign s1.valid = v_s1;
	assign s1.clear = clear_s1;

	brs_window #(
		.RISE_MAX   (RISE_MAX),
		.SAMPLE_BITS(SAMPLE_BITS),
		.TOT_W      (TOT_W),
		.LEN_W      (LEN_W)
	) u_window (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.start (item.start_of_record),
		.sample(sample),
		.len   (len_eff),
		.reload(reload),
		.busy  (busy),
		.total (total)
	);

	brs_iir #(
		.TOT_W(TOT_W)
	) u_iir (
		.clk         (clk),
		.arst_n      (arst_n),
		.s1          (s1),
		.total       (total),
		.recip       (recip_q),
		.decay       (decay_q),
		.result_stall(result_stall),
		.take        (take),
		.result_valid(result_valid),
		.result      (result)
	);

endmodule
